// ===== src/salru_pkg.sv =====
package salru_pkg;

  localparam int TOTAL_W      = 32;
  localparam int OP_W         = 2;
  localparam int OUTCOME_W    = 2;
  localparam int ADDR_W       = 64;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 6;
  localparam int SET_BITS_W   = 3;
  localparam int BLOCK_BITS_W = 6;
  localparam int WAYS_CFG_W   = 4;
  // wide enough for any way index of a set with up to 32 lines
  localparam int WAY_IDX_W    = 5;

  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_STORE  = 2'd1;
  localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;

  localparam logic [OUTCOME_W-1:0] OUT_MISS  = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUT_HIT   = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUT_EVICT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

  typedef logic [WAY_IDX_W-1:0] way_idx_t;

  typedef struct packed {
    logic     hit;
    way_idx_t hit_way;
    logic     inv;
    way_idx_t inv_way;
    way_idx_t min_way;
  } scan_res_t;

  function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

endpackage

// ===== src/salru_store.sv =====
module salru_store #(
  parameter int DEPTH  = 512,
  parameter int ADDR_W = 9,
  parameter int DATA_W = 65
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/salru_cmp.sv =====
module salru_cmp #(
  parameter int TAG_BITS   = 32,
  parameter int STAMP_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  en,
  input  salru_pkg::way_idx_t   way,
  input  logic                  ent_valid,
  input  logic [TAG_BITS-1:0]   ent_tag,
  input  logic [STAMP_BITS-1:0] ent_stamp,
  input  logic [TAG_BITS-1:0]   ref_tag,
  output salru_pkg::scan_res_t  res
);

  import salru_pkg::*;

  scan_res_t             res_r, res_nxt;
  logic [STAMP_BITS-1:0] min_stamp_r, min_stamp_nxt;
  logic                  first_r, first_nxt;

  // one way per call: tag match, first invalid way, oldest stamp
  always_comb begin
    res_nxt       = res_r;
    min_stamp_nxt = min_stamp_r;
    first_nxt     = first_r;
    if (start) begin
      res_nxt.hit = 1'b0;
      res_nxt.inv = 1'b0;
      first_nxt   = 1'b1;
    end else if (en) begin
      if (ent_valid && (ent_tag == ref_tag) && !res_r.hit) begin
        res_nxt.hit     = 1'b1;
        res_nxt.hit_way = way;
      end
      if (!ent_valid && !res_r.inv) begin
        res_nxt.inv     = 1'b1;
        res_nxt.inv_way = way;
      end
      // strict less-than keeps the lowest way on a tie
      if (first_r || (ent_stamp < min_stamp_r)) begin
        min_stamp_nxt   = ent_stamp;
        res_nxt.min_way = way;
      end
      first_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r   <= '0;
      first_r <= 1'b1;
    end else begin
      res_r   <= res_nxt;
      first_r <= first_nxt;
    end
    min_stamp_r <= min_stamp_nxt;
  end

  assign res = res_r;

endmodule

// ===== src/set_assoc_lru_cache_model.sv =====
// Load or store: a taken request passes decode, a way-by-way scan of the N ways in use
// through the shared compare unit, and a write of the picked line before the result
// registers load; a modify adds a second write, an unused operation code skips to the result.
// The next request is taken only after the result registers load, and out_ready can hold them.
// Reset (synchronous, active low) clears totals and registers, then a clearing pass over all
// WAYS << MAX_SET_BITS lines (512 by default) empties the store before the first request.
module set_assoc_lru_cache_model #(
  parameter int MAX_SET_BITS = 6,
  parameter int WAYS         = 8,
  parameter int TAG_BITS     = 32,
  parameter int STAMP_BITS   = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [salru_pkg::OP_W-1:0]          in_operation,
  input  logic [salru_pkg::ADDR_W-1:0]        in_address,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [salru_pkg::OUTCOME_W-1:0]     out_outcome,
  output logic                                out_second_hit,
  output logic [salru_pkg::TOTAL_W-1:0]       out_hits_total,
  output logic [salru_pkg::TOTAL_W-1:0]       out_misses_total,
  output logic [salru_pkg::TOTAL_W-1:0]       out_evictions_total,
  input  logic                                cfg_we,
  input  logic [salru_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [salru_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  import salru_pkg::*;

  localparam int NUM_SETS  = 1 << MAX_SET_BITS;
  localparam int NUM_LINES = NUM_SETS * WAYS;
  localparam int SET_W     = (MAX_SET_BITS < 1) ? 1 : MAX_SET_BITS;
  localparam int LINE_W    = (NUM_LINES < 2) ? 1 : $clog2(NUM_LINES);
  localparam int CNT_W     = $clog2(WAYS + 1);
  localparam int ENT_W     = 1 + TAG_BITS + STAMP_BITS;
  localparam int SB_W      = 4;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_DEC    = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_WRITE  = 3'd4;
  localparam logic [2:0] ST_MOD    = 3'd5;
  localparam logic [2:0] ST_FINISH = 3'd6;

  function automatic logic [LINE_W-1:0] line_of(input logic [SET_W-1:0] s,
                                                input logic [CNT_W-1:0] w);
    return LINE_W'(LINE_W'(s) * LINE_W'(WAYS)) + LINE_W'(w);
  endfunction

  // configuration
  logic [SET_BITS_W-1:0]   set_bits_r;
  logic [BLOCK_BITS_W-1:0] block_bits_r;
  logic [WAYS_CFG_W-1:0]   ways_cfg_r;

  // sequencer and request context
  logic [2:0]            state_r, state_nxt;
  logic [LINE_W-1:0]     clr_idx_r, clr_idx_nxt;
  logic [OP_W-1:0]       op_r, op_nxt;
  logic [ADDR_W-1:0]     a_r, a_nxt;
  logic [CNT_W-1:0]      nw_r, nw_nxt;
  logic [SET_W-1:0]      set_r, set_nxt;
  logic [TAG_BITS-1:0]   tag_r, tag_nxt;
  logic [STAMP_BITS-1:0] clk_r, clk_nxt, clk_inc;
  logic [CNT_W-1:0]      iss_way_r, iss_way_nxt;
  logic [CNT_W-1:0]      cmp_way_r, cmp_way_nxt;
  logic                  cmp_en_r, cmp_en_nxt;
  logic [CNT_W-1:0]      acc_way_r, acc_way_nxt;
  logic [OUTCOME_W-1:0]  outcome_r, outcome_nxt;
  logic                  second_r, second_nxt;
  logic [TOTAL_W-1:0]    hit_r, hit_nxt;
  logic [TOTAL_W-1:0]    miss_r, miss_nxt;
  logic [TOTAL_W-1:0]    evict_r, evict_nxt;

  // result registers
  logic                  out_valid_r, out_valid_nxt;
  logic [OUTCOME_W-1:0]  out_outcome_r;
  logic                  out_second_r;
  logic [TOTAL_W-1:0]    out_hits_r, out_misses_r, out_evicts_r;
  logic                  out_load;

  // decode helpers
  logic [SB_W-1:0]       sb;
  logic [SET_W-1:0]      set_mask;
  logic [ADDR_W-1:0]     a_sh;

  // store and compare unit
  logic                  mem_we, mem_re;
  logic [LINE_W-1:0]     mem_waddr, mem_raddr;
  logic [ENT_W-1:0]      mem_wdata, mem_rdata;
  logic                  scan_start;
  scan_res_t             scan_res;
  logic [CNT_W-1:0]      pick_way;

  salru_store #(
    .DEPTH  (NUM_LINES),
    .ADDR_W (LINE_W),
    .DATA_W (ENT_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  salru_cmp #(
    .TAG_BITS   (TAG_BITS),
    .STAMP_BITS (STAMP_BITS)
  ) u_cmp (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (scan_start),
    .en        (cmp_en_r),
    .way       (WAY_IDX_W'(cmp_way_r)),
    .ent_valid (mem_rdata[ENT_W-1]),
    .ent_tag   (mem_rdata[TAG_BITS+STAMP_BITS-1:STAMP_BITS]),
    .ent_stamp (mem_rdata[STAMP_BITS-1:0]),
    .ref_tag   (tag_r),
    .res       (scan_res)
  );

  assign sb       = (32'(set_bits_r) > MAX_SET_BITS) ? SB_W'(MAX_SET_BITS)
                                                     : SB_W'(set_bits_r);
  assign set_mask = ~({SET_W{1'b1}} << sb);
  assign a_sh     = a_r >> sb;
  assign clk_inc  = (clk_r == '1) ? clk_r : clk_r + 1'b1;
  assign in_ready = (state_r == ST_IDLE);
  assign out_load = (state_r == ST_FINISH) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    op_nxt      = op_r;
    a_nxt       = a_r;
    nw_nxt      = nw_r;
    set_nxt     = set_r;
    tag_nxt     = tag_r;
    clk_nxt     = clk_r;
    iss_way_nxt = iss_way_r;
    cmp_way_nxt = cmp_way_r;
    cmp_en_nxt  = 1'b0;
    acc_way_nxt = acc_way_r;
    outcome_nxt = outcome_r;
    second_nxt  = second_r;
    hit_nxt     = hit_r;
    miss_nxt    = miss_r;
    evict_nxt   = evict_r;
    mem_we      = 1'b0;
    mem_waddr   = line_of(set_r, acc_way_r);
    mem_wdata   = {1'b1, tag_r, clk_r};
    mem_re      = 1'b0;
    mem_raddr   = line_of(set_r, iss_way_r);
    scan_start  = 1'b0;
    pick_way    = CNT_W'(scan_res.min_way);

    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_r;
        mem_wdata = '0;
        if (clr_idx_r == LINE_W'(NUM_LINES - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt      = in_operation;
          a_nxt       = in_address >> block_bits_r;
          outcome_nxt = OUT_MISS;
          second_nxt  = 1'b0;
          if (ways_cfg_r == '0) begin
            nw_nxt = CNT_W'(1);
          end else if (32'(ways_cfg_r) > WAYS) begin
            nw_nxt = CNT_W'(WAYS);
          end else begin
            nw_nxt = CNT_W'(ways_cfg_r);
          end
          case (in_operation)
            OP_LOAD, OP_STORE, OP_MODIFY: state_nxt = ST_DEC;
            default: state_nxt = ST_FINISH;
          endcase
        end
      end
      ST_DEC: begin
        set_nxt     = a_r[SET_W-1:0] & set_mask;
        tag_nxt     = a_sh[TAG_BITS-1:0];
        clk_nxt     = clk_inc;
        iss_way_nxt = '0;
        scan_start  = 1'b1;
        state_nxt   = ST_SCAN;
      end
      ST_SCAN: begin
        if (iss_way_r < nw_r) begin
          mem_re      = 1'b1;
          iss_way_nxt = iss_way_r + 1'b1;
          cmp_en_nxt  = 1'b1;
          cmp_way_nxt = iss_way_r;
        end
        if (cmp_en_r && (cmp_way_r == nw_r - 1'b1)) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (scan_res.hit) begin
          pick_way    = CNT_W'(scan_res.hit_way);
          outcome_nxt = OUT_HIT;
          hit_nxt     = sat_inc(hit_r);
        end else if (scan_res.inv) begin
          pick_way    = CNT_W'(scan_res.inv_way);
          outcome_nxt = OUT_MISS;
          miss_nxt    = sat_inc(miss_r);
        end else begin
          outcome_nxt = OUT_EVICT;
          miss_nxt    = sat_inc(miss_r);
          evict_nxt   = sat_inc(evict_r);
        end
        acc_way_nxt = pick_way;
        mem_we      = 1'b1;
        mem_waddr   = line_of(set_r, pick_way);
        state_nxt   = (op_r == OP_MODIFY) ? ST_MOD : ST_FINISH;
      end
      ST_MOD: begin
        // second access lands on the line just touched
        clk_nxt    = clk_inc;
        mem_we     = 1'b1;
        mem_wdata  = {1'b1, tag_r, clk_inc};
        hit_nxt    = sat_inc(hit_r);
        second_nxt = 1'b1;
        state_nxt  = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r   <= '0;
      block_bits_r <= '0;
      ways_cfg_r   <= WAYS_CFG_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SET_BITS:   set_bits_r   <= cfg_wdata[SET_BITS_W-1:0];
        CFG_BLOCK_BITS: block_bits_r <= cfg_wdata[BLOCK_BITS_W-1:0];
        CFG_WAYS:       ways_cfg_r   <= cfg_wdata[WAYS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      clk_r       <= '0;
      hit_r       <= '0;
      miss_r      <= '0;
      evict_r     <= '0;
      cmp_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      clk_r       <= clk_nxt;
      hit_r       <= hit_nxt;
      miss_r      <= miss_nxt;
      evict_r     <= evict_nxt;
      cmp_en_r    <= cmp_en_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    a_r       <= a_nxt;
    nw_r      <= nw_nxt;
    set_r     <= set_nxt;
    tag_r     <= tag_nxt;
    iss_way_r <= iss_way_nxt;
    cmp_way_r <= cmp_way_nxt;
    acc_way_r <= acc_way_nxt;
    outcome_r <= outcome_nxt;
    second_r  <= second_nxt;
    if (out_load) begin
      out_outcome_r <= outcome_r;
      out_second_r  <= second_r;
      out_hits_r    <= hit_r;
      out_misses_r  <= miss_r;
      out_evicts_r  <= evict_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_outcome         = out_outcome_r;
  assign out_second_hit      = out_second_r;
  assign out_hits_total      = out_hits_r;
  assign out_misses_total    = out_misses_r;
  assign out_evictions_total = out_evicts_r;

endmodule
